FILE: src/assert_macros.svh
// Assertion macros shared by the keyframe interpolator RTL.
// Depends on nothing; include by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset.
`define KLI_ASSERT(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check that an antecedent implies a consequent in the same cycle.
`define KLI_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define KLI_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/kli_pkg.sv
// Shared constants, types and codes of the keyframe interpolator.
// Depends on nothing; imported by the interfaces and the top level.
package kli_pkg;

  localparam int MAX_KEYS  = 64;
  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int OP_W      = 2;
  localparam int ADDR_W    = $clog2(MAX_KEYS);
  localparam int CNT_W     = $clog2(MAX_KEYS + 1);
  localparam int NUM_W     = DATA_W + 1 + FRAC_BITS;
  localparam int DIV_CNT_W = $clog2(NUM_W);
  localparam int PROD_W    = 2 * DATA_W + 1;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic [STATUS_W-1:0]      status_t;
  typedef logic [OP_W-1:0]          op_t;

  localparam op_t OP_APPEND = OP_W'(0);
  localparam op_t OP_QUERY  = OP_W'(1);
  localparam op_t OP_CLEAR  = OP_W'(2);

  localparam status_t ST_OK       = STATUS_W'(0);
  localparam status_t ST_HELD     = STATUS_W'(1);
  localparam status_t ST_EMPTY    = STATUS_W'(2);
  localparam status_t ST_ZERO_GAP = STATUS_W'(3);
  localparam status_t ST_FULL     = STATUS_W'(4);

  localparam word_t VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam word_t VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};

endpackage

FILE: src/kli_in_if.sv
// Input channel of the keyframe interpolator: one command word per handshake.
// Depends on kli_pkg.
interface kli_in_if import kli_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   operation;
  word_t key_frame;
  word_t key_value;
  word_t query_frame;

  modport source(output valid, output operation, output key_frame,
                 output key_value, output query_frame, input ready);
  modport sink(input valid, input operation, input key_frame,
               input key_value, input query_frame, output ready);
endinterface

FILE: src/kli_out_if.sv
// Output channel of the keyframe interpolator: one result word per handshake.
// Depends on kli_pkg.
interface kli_out_if import kli_pkg::*; ();
  logic    valid;
  logic    ready;
  word_t   result_value;
  status_t status;

  modport source(output valid, output result_value, output status, input ready);
  modport sink(input valid, input result_value, input status, output ready);
endinterface

FILE: src/keyframe_linear_interp_core.sv
// Piecewise linear keyframe interpolator: key table in RAM, scan, divide, scale.
// Depends on kli_pkg, kli_in_if, kli_out_if, kli_ram and assert_macros.svh.
//
// Each input word is an append, a query, a clear or an unused code and gives
// exactly one result word. Keys live in two one-port-read RAMs (frames, values)
// of MAX_KEYS entries; only the key count, the state and the output valid are
// cleared by reset, so the block is ready right after reset. One word is worked
// on at a time; the next word is taken once the current result sits in the
// output register, even while that register still waits for the sink. Append,
// clear and unused codes, and a query on an empty table, go straight from
// accept to the output register. A query ends after the scan when it holds the
// first key, after the fetch of the earlier key for a zero gap, and otherwise
// goes on through the divide, factor, multiply, round and sum steps, where the
// scan reads k keys (1 to the key count). The scan reads one key per cycle from
// the RAM read port, and the factor comes from a restoring divider that makes
// one quotient bit per cycle over NUM_W bits.
`include "assert_macros.svh"

module keyframe_linear_interp_core import kli_pkg::*; (
  input logic       clk,
  input logic       rst,
  kli_in_if.sink    in_ch,
  kli_out_if.source out_ch
);

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_LOW  = 9'b000000100,
    S_DIV  = 9'b000001000,
    S_FACT = 9'b000010000,
    S_MUL  = 9'b000100000,
    S_RND  = 9'b001000000,
    S_SUM  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  localparam logic signed [PROD_W-1:0] HALF = PROD_W'((1 << FRAC_BITS) >> 1);
  localparam logic [NUM_W-1:0] FACT_POS_LIM = NUM_W'(VAL_MAX);
  localparam logic [NUM_W-1:0] FACT_NEG_LIM = NUM_W'({1'b1, {(DATA_W-1){1'b0}}});

  state_t                     state;
  logic [CNT_W-1:0]           key_count;
  logic [ADDR_W-1:0]          idx;
  word_t                      q;
  word_t                      fn;
  word_t                      vn;
  word_t                      vp;
  logic signed [DATA_W:0]     dv;
  logic                       neg;
  logic [NUM_W-1:0]           quo;
  logic [DATA_W+1:0]          rem;
  logic [DATA_W:0]            divisor;
  logic [DIV_CNT_W-1:0]       div_cnt;
  word_t                      factor;
  logic signed [PROD_W-1:0]   prod;
  logic signed [PROD_W-1:0]   delta;
  word_t                      res;
  status_t                    res_status;
  logic                       out_valid;
  word_t                      out_result;
  status_t                    out_status;

  logic                       in_fire;
  logic                       out_load;
  logic                       wr_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic [DATA_W-1:0]          frame_rd;
  logic [DATA_W-1:0]          value_rd;
  logic                       scan_hit;
  logic                       scan_last;
  logic                       scan_stop;
  logic signed [DATA_W:0]     offset;
  logic signed [DATA_W:0]     gap;
  logic [DATA_W:0]            off_mag;
  logic [DATA_W:0]            gap_mag;
  logic [DATA_W+1:0]          trial;
  logic                       trial_ge;
  logic signed [PROD_W:0]     sum;

  // One word in flight: take a new one only from idle.
  assign in_ch.ready = (state == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  assign out_ch.valid        = out_valid;
  assign out_ch.result_value = out_result;
  assign out_ch.status       = out_status;

  // Move the finished result into the output register once it is free.
  assign out_load = (state == S_DONE) && (!out_valid || out_ch.ready);

  // Appends write only from idle and read data is used only while a query runs,
  // so a write never overlaps a read whose data is used.
  assign wr_en = in_fire && (in_ch.operation == OP_APPEND)
                 && (key_count < CNT_W'(MAX_KEYS));

  // Scan compares the key read last cycle and fetches the next one; on a stop,
  // fetch the key below it as the earlier end of the segment.
  assign scan_hit  = $signed(frame_rd) > q;
  assign scan_last = ({1'b0, idx} == key_count - CNT_W'(1));
  assign scan_stop = scan_hit || scan_last;

  always_comb begin
    rd_addr = '0;
    if (state == S_SCAN) begin
      rd_addr = scan_stop ? idx - ADDR_W'(1) : idx + ADDR_W'(1);
    end
  end

  kli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) frame_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (key_count[ADDR_W-1:0]),
    .wr_data (in_ch.key_frame),
    .rd_addr (rd_addr),
    .rd_data (frame_rd)
  );

  kli_ram #(.WIDTH(DATA_W), .DEPTH(MAX_KEYS)) value_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (key_count[ADDR_W-1:0]),
    .wr_data (in_ch.key_value),
    .rd_addr (rd_addr),
    .rd_data (value_rd)
  );

  // Segment differences, exact in 33 bits; the earlier key comes from the RAM.
  assign offset  = (DATA_W+1)'(q) - (DATA_W+1)'($signed(frame_rd));
  assign gap     = (DATA_W+1)'(fn) - (DATA_W+1)'($signed(frame_rd));
  assign off_mag = offset[DATA_W] ? -offset : offset;
  assign gap_mag = gap[DATA_W] ? -gap : gap;

  // One restoring step: shift in the next numerator bit, subtract if it fits.
  assign trial    = {rem[DATA_W:0], quo[NUM_W-1]};
  assign trial_ge = trial >= {1'b0, divisor};

  // Saturate to 32 bits when the upper bits are not all sign copies.
  assign sum = (PROD_W+1)'(vp) + (PROD_W+1)'(delta);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      key_count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            unique case (in_ch.operation)
              OP_APPEND: begin
                if (key_count < CNT_W'(MAX_KEYS)) begin
                  key_count <= key_count + CNT_W'(1);
                end
                state <= S_DONE;
              end
              OP_CLEAR: begin
                key_count <= '0;
                state     <= S_DONE;
              end
              OP_QUERY: begin
                state <= (key_count == '0) ? S_DONE : S_SCAN;
              end
              default: begin
                state <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (scan_stop) begin
            state <= (idx == '0) ? S_DONE : S_LOW;
          end
        end
        S_LOW: begin
          state <= (gap == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (div_cnt == DIV_CNT_W'(NUM_W - 1)) begin
            state <= S_FACT;
          end
        end
        S_FACT: state <= S_MUL;
        S_MUL:  state <= S_RND;
        S_RND:  state <= S_SUM;
        S_SUM:  state <= S_DONE;
        S_DONE: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: no reset, every one is written before it is read.
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_result <= res;
      out_status <= res_status;
    end

    unique case (state)
      S_IDLE: begin
        q          <= in_ch.query_frame;
        idx        <= '0;
        res        <= '0;
        if (in_fire) begin
          unique case (in_ch.operation)
            OP_APPEND: begin
              res_status <= (key_count < CNT_W'(MAX_KEYS)) ? ST_OK : ST_FULL;
            end
            OP_QUERY: begin
              res_status <= (key_count == '0) ? ST_EMPTY : ST_OK;
            end
            default: begin
              res_status <= ST_OK;
            end
          endcase
        end else begin
          res_status <= ST_OK;
        end
      end
      S_SCAN: begin
        if (scan_stop) begin
          // The later key is always the one that stopped the scan.
          fn         <= $signed(frame_rd);
          vn         <= $signed(value_rd);
          res        <= $signed(value_rd);
          res_status <= ST_HELD;
        end else begin
          idx <= idx + ADDR_W'(1);
        end
      end
      S_LOW: begin
        vp         <= $signed(value_rd);
        res        <= $signed(value_rd);
        res_status <= ST_ZERO_GAP;
        neg        <= offset[DATA_W] ^ gap[DATA_W];
        quo        <= NUM_W'(off_mag) << FRAC_BITS;
        rem        <= '0;
        divisor    <= gap_mag;
        div_cnt    <= '0;
        dv         <= (DATA_W+1)'(vn) - (DATA_W+1)'($signed(value_rd));
      end
      S_DIV: begin
        rem     <= trial_ge ? trial - {1'b0, divisor} : trial;
        quo     <= {quo[NUM_W-2:0], trial_ge};
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end
      S_FACT: begin
        if (neg) begin
          factor <= (quo > FACT_NEG_LIM) ? VAL_MIN : -$signed(quo[DATA_W-1:0]);
        end else begin
          factor <= (quo > FACT_POS_LIM) ? VAL_MAX : $signed(quo[DATA_W-1:0]);
        end
      end
      S_MUL: begin
        prod <= dv * factor;
      end
      S_RND: begin
        // Round half up: floor of (product + half) over the fraction.
        delta <= (prod + HALF) >>> FRAC_BITS;
      end
      S_SUM: begin
        res_status <= ST_OK;
        if (sum[PROD_W:DATA_W-1] == '0 || sum[PROD_W:DATA_W-1] == '1) begin
          res <= sum[DATA_W-1:0];
        end else begin
          res <= sum[PROD_W] ? VAL_MIN : VAL_MAX;
        end
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  `KLI_ASSERT(a_count_bound, clk, rst, key_count <= CNT_W'(MAX_KEYS), "key count above table size")
  `KLI_ASSERT_IMP(a_scan_in_table, clk, rst, state == S_SCAN, {1'b0, idx} < key_count, "scan past appended keys")
  `KLI_ASSERT_IMP(a_low_has_pred, clk, rst, state == S_LOW, idx != '0, "segment without an earlier key")
  `KLI_ASSERT_NXT(a_full_drops, clk, rst, wr_en == 1'b0 && in_fire && in_ch.operation == OP_APPEND, key_count == $past(key_count), "append to full table changed count")

endmodule

FILE: src/kli_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module kli_ram #(
  parameter int  WIDTH = 32,
  parameter int  DEPTH = 64,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
